// ===== hw/rtl/ssh_ils_pkg.sv =====
package ssh_ils_pkg;

  localparam int OFFSET_BITS   = 17;
  localparam int LEN_BITS      = 11;
  localparam int PREAMBLE_BITS = 16;
  localparam int CAP_BITS      = 10;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = PREAMBLE_BITS;

  localparam logic [PREAMBLE_BITS-1:0] PREAMBLE_RESET = PREAMBLE_BITS'(8192);
  localparam logic [CAP_BITS-1:0]      CAP_RESET      = CAP_BITS'(255);

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PREAMBLE_LIMIT = 1'd0,
    CFG_LINE_CAP       = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } scan_in_t;

  typedef struct packed {
    status_t                status;
    logic [OFFSET_BITS-1:0] end_offset;
  } scan_out_t;

  typedef struct packed {
    status_t                verdict;
    logic [OFFSET_BITS-1:0] stream_offset;
    logic [LEN_BITS-1:0]    line_length;
    logic                   pending_cr;
    logic                   prefix_match;
    logic                   version_match;
    logic [OFFSET_BITS-1:0] found_offset;
  } scan_state_t;

  function automatic scan_state_t scan_clear();
    scan_state_t s;
    s.verdict       = ST_MORE;
    s.stream_offset = '0;
    s.line_length   = '0;
    s.pending_cr    = 1'b0;
    s.prefix_match  = 1'b1;
    s.version_match = 1'b1;
    s.found_offset  = '0;
    return s;
  endfunction

  // "SSH-"
  function automatic logic [7:0] prefix_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h53;
      2'd1:    c = 8'h53;
      2'd2:    c = 8'h48;
      default: c = 8'h2d;
    endcase
    return c;
  endfunction

  // "2.0-"
  function automatic logic [7:0] version_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h32;
      2'd1:    c = 8'h2e;
      2'd2:    c = 8'h30;
      default: c = 8'h2d;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/ssh_ils_in_if.sv =====
interface ssh_ils_in_if;
  import ssh_ils_pkg::*;
  logic     valid;
  logic     ready;
  scan_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ssh_ils_out_if.sv =====
interface ssh_ils_out_if;
  import ssh_ils_pkg::*;
  logic      valid;
  logic      ready;
  scan_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ssh_ils_next.sv =====
module ssh_ils_next (
  input  ssh_ils_pkg::scan_state_t                   st,
  input  logic [7:0]                                 data_byte,
  input  logic                                       first,
  input  logic [ssh_ils_pkg::PREAMBLE_BITS-1:0]      preamble_limit,
  input  logic [ssh_ils_pkg::CAP_BITS-1:0]           line_cap,
  output ssh_ils_pkg::scan_state_t                   st_next
);
  import ssh_ils_pkg::*;

  localparam int W = LEN_BITS + 1;

  scan_state_t            cur;
  logic [OFFSET_BITS-1:0] next_off;
  logic [LEN_BITS-1:0]    len_inc;
  logic [W-1:0]           cap_ext;
  logic [W-1:0]           need_done;
  logic [W-1:0]           need_more;
  logic                   eol;

  assign cur      = first ? scan_clear() : st;
  assign next_off = (&cur.stream_offset) ? cur.stream_offset
                                         : cur.stream_offset + OFFSET_BITS'(1);
  assign len_inc  = (&cur.line_length) ? cur.line_length
                                       : cur.line_length + LEN_BITS'(1);
  assign cap_ext  = W'(line_cap);
  assign eol      = cur.pending_cr && (data_byte == CHAR_LF);
  // content + 2, where content drops the counted CR
  assign need_done = W'(cur.line_length) + W'(1);
  assign need_more = W'(len_inc) + W'(2) - W'(data_byte == CHAR_CR);

  always_comb begin
    st_next = cur;
    if (cur.verdict == ST_MORE) begin
      st_next.stream_offset = next_off;
      if (eol) begin
        if (need_done > cap_ext) begin
          st_next.verdict = ST_ERROR;
        end else if (cur.line_length >= LEN_BITS'(5) && cur.prefix_match) begin
          if (cur.line_length < LEN_BITS'(9) || !cur.version_match) begin
            st_next.verdict = ST_ERROR;
          end else begin
            st_next.verdict      = ST_FOUND;
            st_next.found_offset = next_off;
          end
        end else begin
          st_next.line_length   = '0;
          st_next.pending_cr    = 1'b0;
          st_next.prefix_match  = 1'b1;
          st_next.version_match = 1'b1;
          if (next_off > OFFSET_BITS'(preamble_limit) || line_cap < CAP_BITS'(2)) begin
            st_next.verdict = ST_ERROR;
          end
        end
      end else begin
        if (cur.line_length < LEN_BITS'(4)) begin
          if (data_byte != prefix_char(cur.line_length[1:0])) begin
            st_next.prefix_match = 1'b0;
          end
        end else if (cur.line_length < LEN_BITS'(8)) begin
          if (data_byte != version_char(cur.line_length[1:0])) begin
            st_next.version_match = 1'b0;
          end
        end
        st_next.line_length = len_inc;
        st_next.pending_cr  = (data_byte == CHAR_CR);
        if (need_more > cap_ext) begin
          st_next.verdict = ST_ERROR;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/ssh_ident_line_scanner.sv =====
// SSH identification line scanner.
//
// in_ch carries one stream byte per request plus a first flag that clears
// the scanner before that byte, starting a new stream. out_ch returns exactly
// one result per byte: status (more / found / error) and, when found, the
// offset just past the identification line's LF.
// preamble_limit and line_cap are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// Latency: the result of a byte is valid the cycle after it is accepted.
// Throughput: one byte per cycle while out_ch does not stall; the per-byte compare and counter update
// sits between the input handshake and the result register.
// Found and error are sticky until a byte with first set arrives.
// Reset (rst, synchronous) loads preamble_limit = 8192, line_cap = 255,
// clears the scanner and clears the result valid flag.
// When out_ch stalls, the pending result holds and in_ch takes no new byte;
// a byte is taken in the same cycle the held result is drained.
module ssh_ident_line_scanner (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ssh_ils_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ssh_ils_pkg::CFG_DATA_BITS-1:0] cfg_data,
  ssh_ils_in_if.sink                           in_ch,
  ssh_ils_out_if.source                        out_ch
);
  import ssh_ils_pkg::*;

  logic [PREAMBLE_BITS-1:0] preamble_limit;
  logic [CAP_BITS-1:0]      line_cap;
  scan_state_t              st;
  scan_state_t              st_next;
  logic                     out_valid;
  scan_out_t                out_payload;
  logic                     accept;

  assign in_ch.ready    = !out_valid || out_ch.ready;
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_payload;

  ssh_ils_next u_next (
    .st             (st),
    .data_byte      (in_ch.payload.data_byte),
    .first          (in_ch.payload.first),
    .preamble_limit (preamble_limit),
    .line_cap       (line_cap),
    .st_next        (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_limit <= PREAMBLE_RESET;
      line_cap       <= CAP_RESET;
      st             <= scan_clear();
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PREAMBLE_LIMIT: preamble_limit <= cfg_data[PREAMBLE_BITS-1:0];
          CFG_LINE_CAP:       line_cap       <= cfg_data[CAP_BITS-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        st                     <= st_next;
        out_valid              <= 1'b1;
        out_payload.status     <= st_next.verdict;
        out_payload.end_offset <= (st_next.verdict == ST_FOUND) ? st_next.found_offset
                                                                : '0;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.verdict != ST_MORE && !(accept && in_ch.payload.first))
      |=> st.verdict == $past(st.verdict))
    else $error("final verdict changed without a new stream");

  a_offset_only_found: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_payload.status != ST_FOUND) |-> out_payload.end_offset == '0)
    else $error("end_offset set without a found status");

  a_cr_counted: assert property (@(posedge clk) disable iff (rst)
    st.pending_cr |-> st.line_length != '0)
    else $error("pending CR with empty line");

  a_found_past_line: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_payload.status == ST_FOUND)
      |-> out_payload.end_offset >= OFFSET_BITS'(10))
    else $error("found offset shorter than a minimal identification line");

endmodule
